/* rtl/ssq_pkg.sv */
// Shared types, codes and the fixed step tables of the servo step sequencer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ssq_pkg;

    localparam int CH_W      = 4;
    localparam int PULSE_W   = 12;
    localparam int TIME_W    = 16;
    localparam int MS_W      = 32;
    localparam int LAST_STEP = 3;

    localparam logic [MS_W-1:0] HOLD_SHORT_MS = 32'd300;
    localparam logic [MS_W-1:0] HOLD_LONG_MS  = 32'd1000;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_HOME  = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        CLASS_A       = 2'd0,
        CLASS_B       = 2'd1,
        CLASS_C       = 2'd2,
        CLASS_UNKNOWN = 2'd3
    } class_code_t;

    typedef enum logic [1:0] {
        REG_PULSE_MIN   = 2'd0,
        REG_PULSE_MAX   = 2'd1,
        REG_GATE_OPEN   = 2'd2,
        REG_ARRIVE_WAIT = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        ANG_0   = 2'd0,
        ANG_90  = 2'd1,
        ANG_180 = 2'd2
    } angle_t;

    typedef enum logic [2:0] {
        HOLD_SHORT,
        HOLD_LONG,
        HOLD_NONE,
        HOLD_GATE_OPEN,
        HOLD_ARRIVE
    } hold_t;

    // Servo channels driven by the sequences.
    localparam logic CH_GATE = 1'b0;
    localparam logic CH_DIV  = 1'b1;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_WRITE,
        JOB_HOME,
        JOB_STOP
    } job_kind_t;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] class_id;
    } cmd_t;

    typedef struct packed {
        logic               write_valid;
        logic [CH_W-1:0]    channel;
        logic [PULSE_W-1:0] pulse;
        logic               sequence_done;
        logic               busy_res;
        logic               ignored;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_min;
        logic [PULSE_W-1:0] pulse_max;
        logic [TIME_W-1:0]  gate_open_ms;
        logic [TIME_W-1:0]  arrive_wait_ms;
    } cfg_t;

    // One classified request handed from the front end to the back end.
    typedef struct packed {
        job_kind_t kind;
        logic      ch;
        angle_t    angle;
        logic      done;
        logic      busy;
        logic      ign;
    } job_t;

    typedef struct packed {
        logic   ch;
        angle_t angle;
        hold_t  hold;
    } step_t;

    // Fixed step tables; an unreachable select of three runs as sequence A.
    function automatic step_t step_lookup(logic [1:0] sel, logic [1:0] step);
        step_t s;
        s = '{ch: CH_GATE, angle: ANG_0, hold: HOLD_NONE};
        if (sel == CLASS_B || sel == CLASS_C) begin
            case (step)
                2'd0:    s = '{ch: CH_GATE, angle: ANG_0, hold: HOLD_SHORT};
                2'd1:    s = '{ch: CH_GATE, angle: ANG_90, hold: HOLD_ARRIVE};
                2'd2:    s = '{ch: CH_DIV,
                               angle: (sel == CLASS_C) ? ANG_180 : ANG_0,
                               hold: HOLD_LONG};
                default: s = '{ch: CH_DIV, angle: ANG_90, hold: HOLD_NONE};
            endcase
        end else begin
            case (step)
                2'd0:    s = '{ch: CH_DIV, angle: ANG_0, hold: HOLD_SHORT};
                2'd1:    s = '{ch: CH_GATE, angle: ANG_0, hold: HOLD_GATE_OPEN};
                2'd2:    s = '{ch: CH_GATE, angle: ANG_90, hold: HOLD_LONG};
                default: s = '{ch: CH_DIV, angle: ANG_90, hold: HOLD_NONE};
            endcase
        end
        return s;
    endfunction

endpackage

/* rtl/ssq_front.sv */
// Front end: accepts requests, keeps the sequencer state and classifies each
// request into a job for the back end. Depends on ssq_pkg.
`timescale 1ns / 1ps

module ssq_front
    import ssq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    input  logic q_full,
    output logic q_push,
    output job_t q_data
);

    logic            busy_reg, busy_next;
    logic [1:0]      sel_reg, sel_next;
    logic [1:0]      step_reg, step_next;
    logic            written_reg, written_next;
    logic [MS_W-1:0] ms_reg, ms_next;
    logic [MS_W-1:0] start_reg, start_next;

    logic            accept;
    step_t           cur_step;
    step_t           first_step;
    logic [MS_W-1:0] hold;
    logic [MS_W-1:0] ms_inc;
    logic [MS_W-1:0] elapsed;
    job_t            job;

    assign cmd_stall = q_full;
    assign accept    = cmd_valid && !cmd_stall;
    assign q_push    = accept;
    assign q_data    = job;

    assign cur_step   = step_lookup(sel_reg, step_reg);
    assign first_step = step_lookup(cmd.class_id, 2'd0);
    assign ms_inc     = ms_reg + 1'b1;
    assign elapsed    = ms_inc - start_reg;

    always_comb
    begin
        case (cur_step.hold)
            HOLD_SHORT:     hold = HOLD_SHORT_MS;
            HOLD_LONG:      hold = HOLD_LONG_MS;
            HOLD_GATE_OPEN: hold = MS_W'(cfg.gate_open_ms);
            HOLD_ARRIVE:    hold = MS_W'(cfg.arrive_wait_ms);
            default:        hold = '0;
        endcase
    end

    always_comb
    begin
        busy_next    = busy_reg;
        sel_next     = sel_reg;
        step_next    = step_reg;
        written_next = written_reg;
        ms_next      = ms_reg;
        start_next   = start_reg;
        job          = '{kind: JOB_NONE, ch: CH_GATE, angle: ANG_0,
                         done: 1'b0, busy: 1'b0, ign: 1'b0};
        if (accept) begin
            unique case (cmd.command)
                CMD_TICK:
                begin
                    ms_next = ms_inc;
                    if (busy_reg) begin
                        if (!written_reg) begin
                            job.kind     = JOB_WRITE;
                            job.ch       = cur_step.ch;
                            job.angle    = cur_step.angle;
                            written_next = 1'b1;
                            start_next   = ms_inc;
                            if (hold == '0) begin
                                busy_next = 1'b0;
                                job.done  = 1'b1;
                            end
                        end else if (elapsed >= hold) begin
                            if (step_reg == 2'(LAST_STEP)) begin
                                busy_next = 1'b0;
                                job.done  = 1'b1;
                            end else begin
                                step_next    = step_reg + 1'b1;
                                written_next = 1'b0;
                            end
                        end
                    end
                end
                CMD_START:
                begin
                    if (busy_reg || cmd.class_id == CLASS_UNKNOWN) begin
                        job.ign = 1'b1;
                    end else begin
                        sel_next     = cmd.class_id;
                        step_next    = 2'd0;
                        busy_next    = 1'b1;
                        written_next = 1'b1;
                        start_next   = ms_reg;
                        job.kind     = JOB_WRITE;
                        job.ch       = first_step.ch;
                        job.angle    = first_step.angle;
                    end
                end
                CMD_HOME:
                begin
                    if (busy_reg) begin
                        job.ign = 1'b1;
                    end else begin
                        job.kind = JOB_HOME;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    job.kind  = JOB_STOP;
                end
            endcase
        end
        job.busy = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg    <= 1'b0;
            sel_reg     <= '0;
            step_reg    <= '0;
            written_reg <= 1'b0;
            ms_reg      <= '0;
            start_reg   <= '0;
        end else begin
            busy_reg    <= busy_next;
            sel_reg     <= sel_next;
            step_reg    <= step_next;
            written_reg <= written_next;
            ms_reg      <= ms_next;
            start_reg   <= start_next;
        end
    end

    // A stop always leaves the sequencer idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == CMD_STOP |=> !busy_reg)
        else $error("sequencer still busy after stop");

    // The millisecond counter moves only on ticks, by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && cmd.command == CMD_TICK) |=> ms_reg == $past(ms_reg))
        else $error("millisecond counter moved without a tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == CMD_TICK |=> ms_reg == $past(ms_reg) + 1'b1)
        else $error("millisecond counter did not advance on a tick");

    // A job that finishes a sequence always reports idle afterwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_data.done |-> !q_data.busy)
        else $error("finished sequence reported as busy");

endmodule

/* rtl/ssq_queue.sv */
// Short job queue between front end and back end so each side stalls alone.
// Depends on ssq_pkg for the job type.
`timescale 1ns / 1ps

module ssq_queue
    import ssq_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    // Pointers are apart by the fill count, modulo the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 || count_reg == CNT_W'(DEPTH) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && full && !pop |=> count_reg == $past(count_reg))
        else $error("queue accepted a job while full");

endmodule

/* rtl/ssq_back.sv */
// Back end: expands each job into its PWM write or status results, one per
// cycle without a stall, held in the result register. Depends on ssq_pkg.
`timescale 1ns / 1ps

module ssq_back
    import ssq_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_not_empty,
    input  job_t q_head,
    output logic q_pop,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic            cur_valid_reg;
    job_t            cur_job_reg;
    logic [CH_W-1:0] idx_reg;
    logic            out_valid_reg;
    res_t            out_reg;

    logic            out_free;
    logic            advance;
    logic            last_now;
    logic            write_ch;
    angle_t          write_angle;
    res_t            result;

    // Angle to off count; 90 degrees is pulse_min plus span/2 cut toward zero.
    function automatic logic [PULSE_W-1:0] angle_pulse(cfg_t c, angle_t a);
        logic signed [PULSE_W:0] span;
        logic signed [PULSE_W:0] half;
        span = $signed({1'b0, c.pulse_max}) - $signed({1'b0, c.pulse_min});
        half = (span + $signed((PULSE_W + 1)'(span[PULSE_W]))) >>> 1;
        case (a)
            ANG_0:   return c.pulse_min;
            ANG_180: return c.pulse_max;
            default: return c.pulse_min + half[PULSE_W-1:0];
        endcase
    endfunction

    assign out_free  = !out_valid_reg || !res_stall;
    assign advance   = cur_valid_reg && out_free;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        case (cur_job_reg.kind)
            JOB_HOME: last_now = (idx_reg == CH_W'(1));
            JOB_STOP: last_now = (idx_reg == CH_W'(NUM_CHANNELS - 1));
            default:  last_now = 1'b1;
        endcase
    end

    assign q_pop = q_not_empty && (!cur_valid_reg || (advance && last_now));

    always_comb
    begin
        // Home writes the gate first, then the diverter.
        write_ch    = (cur_job_reg.kind == JOB_HOME) ? idx_reg[0] : cur_job_reg.ch;
        write_angle = (cur_job_reg.kind == JOB_HOME) ? ANG_90 : cur_job_reg.angle;
        result               = '0;
        result.sequence_done = cur_job_reg.done;
        result.busy_res      = cur_job_reg.busy;
        result.ignored       = cur_job_reg.ign;
        result.last          = last_now;
        case (cur_job_reg.kind)
            JOB_WRITE, JOB_HOME:
            begin
                result.write_valid = 1'b1;
                result.channel     = CH_W'(write_ch);
                result.pulse       = angle_pulse(cfg, write_angle);
            end
            JOB_STOP:
            begin
                result.write_valid = 1'b1;
                result.channel     = idx_reg;
            end
            default:
            begin
                result.write_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (out_free) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (advance) begin
                idx_reg <= last_now ? '0 : idx_reg + 1'b1;
                if (last_now) begin
                    cur_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_reg <= result;
        end
        if (q_pop) begin
            cur_job_reg <= q_head;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= CH_W'(NUM_CHANNELS - 1))
        else $error("write index past the last channel");

    // A result without a write is the only result of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.write_valid |-> out_reg.last)
        else $error("empty result not marked last");

    // The index only runs while a multi-write job is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cur_valid_reg |-> idx_reg == '0)
        else $error("write index left over with no active job");

endmodule

/* rtl/servo_step_sequencer_core.sv */
// Top level of the servo step sequencer: configuration registers, front end,
// job queue and back end. Depends on ssq_pkg, ssq_front, ssq_queue, ssq_back.
`timescale 1ns / 1ps

// The sequencer runs one of three fixed four-step servo sequences on the gate
// (channel 0) and diverter (channel 1) servos. Each request on the cmd channel
// is a millisecond tick, a start with a sequence class, a home or a stop; the
// block answers every request with one or more result items on the res
// channel, the final one marked by last. A tick or start gives one result,
// home gives two (one if ignored) and stop gives NUM_CHANNELS, one zero write
// per channel. The front end accepts one request per cycle as long as the
// QUEUE_DEPTH-entry job queue has room, so requests are never held up by a
// slow result consumer until that queue fills. The back end issues one result
// per cycle from its result register while res_stall is low, which sets the
// sustained rate; a stop, with NUM_CHANNELS results, is the longest request.
// An accepted request passes through the job queue and the current-job
// register to the result register. Configuration registers are written through
// cfg_we, cfg_index and cfg_data and must only change while no request is
// outstanding. pulse_max may lie below pulse_min; the ninety degree position
// then interpolates downward.

module servo_step_sequencer_core
    import ssq_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int QUEUE_DEPTH  = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [TIME_W-1:0] cfg_data,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cmd_t              cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_push;
    job_t q_push_data;
    logic q_pop;
    logic q_not_empty;
    job_t q_head;

    // Configuration registers, reset to the calibration defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.pulse_min      <= 12'd102;
            cfg_reg.pulse_max      <= 12'd512;
            cfg_reg.gate_open_ms   <= 16'd500;
            cfg_reg.arrive_wait_ms <= 16'd2000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PULSE_MIN:   cfg_reg.pulse_min      <= cfg_data[PULSE_W-1:0];
                REG_PULSE_MAX:   cfg_reg.pulse_max      <= cfg_data[PULSE_W-1:0];
                REG_GATE_OPEN:   cfg_reg.gate_open_ms   <= cfg_data;
                REG_ARRIVE_WAIT: cfg_reg.arrive_wait_ms <= cfg_data;
            endcase
        end
    end

    // The front end owns all sequencing state and decides what each request
    // does; it never waits on the result side except through the queue.
    ssq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    ssq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // The back end turns each job into PWM writes and status results.
    ssq_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res)
    );

endmodule
